>>> rtl/srhc_pkg.sv
package srhc_pkg;

  // header geometry
  localparam int unsigned HdrLen = 40;
  localparam int unsigned PosW   = 6;

  // byte offsets of interest
  localparam logic [PosW-1:0] PosMagic0  = 6'd0;
  localparam logic [PosW-1:0] PosMagic1  = 6'd1;
  localparam logic [PosW-1:0] PosVersion = 6'd2;
  localparam logic [PosW-1:0] PosDoyLo   = 6'd10;
  localparam logic [PosW-1:0] PosDoyHi   = 6'd11;
  localparam logic [PosW-1:0] PosHour    = 6'd12;
  localparam logic [PosW-1:0] PosMinute  = 6'd13;
  localparam logic [PosW-1:0] PosSecond  = 6'd14;
  localparam logic [PosW-1:0] PosFormat  = 6'd15;
  localparam logic [PosW-1:0] PosIdLen   = 6'd33;
  localparam logic [PosW-1:0] PosExtra0  = 6'd34;
  localparam logic [PosW-1:0] PosExtra1  = 6'd35;
  localparam logic [PosW-1:0] PosPay0    = 6'd36;
  localparam logic [PosW-1:0] PosPay1    = 6'd37;
  localparam logic [PosW-1:0] PosPay2    = 6'd38;
  localparam logic [PosW-1:0] PosPay3    = 6'd39;
  localparam logic [PosW-1:0] PosLast    = 6'(HdrLen - 1);

  // field limits
  localparam logic [7:0]  MagicM     = 8'h4D;
  localparam logic [7:0]  MagicS     = 8'h53;
  localparam logic [7:0]  VersionReq = 8'd3;
  localparam logic [15:0] DoyMax     = 16'd366;
  localparam logic [7:0]  HourMax    = 8'd23;
  localparam logic [7:0]  MinuteMax  = 8'd59;
  localparam logic [7:0]  SecondMax  = 8'd60;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       end_of_data;
  } in_word_t;

  typedef struct packed {
    logic        record_ok;
    logic        truncated;
    logic [7:0]  payload_format;
    logic [7:0]  identifier_length;
    logic [15:0] extra_header_length;
    logic [31:0] payload_length;
  } out_word_t;

  // allowed payload encodings
  function automatic logic format_allowed(input logic [7:0] f);
    logic ok;
    case (f)
      8'd0, 8'd1, 8'd3, 8'd4, 8'd5, 8'd10, 8'd11, 8'd14,
      8'd16, 8'd19, 8'd30, 8'd53, 8'd54, 8'd55: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

>>> rtl/srhc_parse.sv
module srhc_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  srhc_pkg::in_word_t  word,
  output logic              emit,
  output srhc_pkg::out_word_t result
);
  import srhc_pkg::*;

  logic [PosW-1:0] byte_position, byte_position_next;
  logic            checks_passed, checks_passed_next;
  logic [7:0]      held_low_byte, held_low_byte_next;
  logic [7:0]      format_seen, format_seen_next;
  logic [7:0]      ident_len_seen, ident_len_seen_next;
  logic [15:0]     extra_len_seen, extra_len_seen_next;
  logic [31:0]     payload_len_seen, payload_len_seen_next;

  logic [7:0]  b;
  logic [15:0] doy;
  logic        ok;
  logic        last;

  always_comb begin
    b   = word.header_byte;
    doy = {b, held_low_byte};
    ok  = 1'b1;
    held_low_byte_next    = held_low_byte;
    format_seen_next      = format_seen;
    ident_len_seen_next   = ident_len_seen;
    extra_len_seen_next   = extra_len_seen;
    payload_len_seen_next = payload_len_seen;

    case (byte_position)
      PosMagic0:  ok = (b == MagicM);
      PosMagic1:  ok = (b == MagicS);
      PosVersion: ok = (b == VersionReq);
      PosDoyLo:   held_low_byte_next = b;
      PosDoyHi:   ok = (doy != 16'd0) && (doy <= DoyMax);
      PosHour:    ok = (b <= HourMax);
      PosMinute:  ok = (b <= MinuteMax);
      PosSecond:  ok = (b <= SecondMax);
      PosFormat: begin
        format_seen_next = b;
        ok = format_allowed(b);
      end
      PosIdLen:   ident_len_seen_next = b;
      PosExtra0:  extra_len_seen_next[7:0] = b;
      PosExtra1:  extra_len_seen_next[15:8] = b;
      PosPay0:    payload_len_seen_next[7:0] = b;
      PosPay1:    payload_len_seen_next[15:8] = b;
      PosPay2:    payload_len_seen_next[23:16] = b;
      PosPay3:    payload_len_seen_next[31:24] = b;
      default:    ok = 1'b1;
    endcase

    checks_passed_next = checks_passed & ok;
    last = (byte_position == PosLast);
    emit = step && (last || word.end_of_data);
    byte_position_next = byte_position + 1'b1;

    result.record_ok           = last & checks_passed_next;
    result.truncated           = ~last;
    result.payload_format      = format_seen_next;
    result.identifier_length   = ident_len_seen_next;
    result.extra_header_length = extra_len_seen_next;
    result.payload_length      = payload_len_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst || emit) begin
      byte_position    <= '0;
      checks_passed    <= 1'b1;
      held_low_byte    <= '0;
      format_seen      <= '0;
      ident_len_seen   <= '0;
      extra_len_seen   <= '0;
      payload_len_seen <= '0;
    end else if (step) begin
      byte_position    <= byte_position_next;
      checks_passed    <= checks_passed_next;
      held_low_byte    <= held_low_byte_next;
      format_seen      <= format_seen_next;
      ident_len_seen   <= ident_len_seen_next;
      extra_len_seen   <= extra_len_seen_next;
      payload_len_seen <= payload_len_seen_next;
    end
  end

endmodule

>>> rtl/seismic_record_header_checker_unit.sv
// channel   dir  handshake             word
// hdr       in   hdr_valid/hdr_ready   in_word_t: header_byte, end_of_data
// res       out  res_valid/res_ready   out_word_t: flags, format, lengths
//
// one header byte per cycle while no result waits on res_ready; a byte waits
// in the input register, and at the edge where it is checked and folded into
// the header state, a finished header's result is loaded into the output register
// reset (rst, synchronous) empties both registers and restarts at offset 0
// a result waiting on res_ready holds the parser, so at most one more byte
// is taken into the input register before hdr_ready drops
module seismic_record_header_checker_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                hdr_valid,
  output logic                hdr_ready,
  input  srhc_pkg::in_word_t  hdr_word,
  output logic                res_valid,
  input  logic                res_ready,
  output srhc_pkg::out_word_t res_word
);
  import srhc_pkg::*;

  // input register
  logic      hq_valid;
  in_word_t  hq_word;

  // parser side
  logic      advance;
  logic      emit;
  out_word_t result;

  // parser moves when the output register is free or being drained
  assign advance   = hq_valid && (!res_valid || res_ready);
  assign hdr_ready = !hq_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hq_valid <= 1'b0;
    end else if (hdr_ready) begin
      hq_valid <= hdr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_ready && hdr_valid) begin
      hq_word <= hdr_word;
    end
  end

  srhc_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .word   (hq_word),
    .emit   (emit),
    .result (result)
  );

  // output register: loads on a finished header, clears when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_word <= result;
    end
  end

endmodule
